>>> sv/b64sc_pkg.sv
// Shared types, constants and alphabet functions for the base64 stream codec.
// Used by b64sc_core, b64sc_emit and base64_stream_codec_top; no dependencies.
package b64sc_pkg;

  // Mode register codes
  localparam logic ModeEnc = 1'b0;
  localparam logic ModeDec = 1'b1;

  // Pad character '=' and the index given to characters outside the alphabet
  localparam logic [7:0] PadChar = 8'h3d;
  localparam logic [7:0] BadIdx  = 8'hff;

  // Most results that one input item can produce
  localparam int unsigned MaxRes = 4;
  localparam int unsigned CntW   = $clog2(MaxRes + 1);
  localparam int unsigned IdxW   = $clog2(MaxRes);

  // One result item
  typedef struct packed {
    logic [7:0] data;
    logic       dvalid;
    logic       last;
  } res_t;

  // All results caused by one input item, entry 0 goes out first
  typedef struct packed {
    res_t [MaxRes-1:0] ent;
    logic [CntW-1:0]   cnt;
  } bundle_t;

  // Map a 6-bit index to its alphabet character
  function automatic logic [7:0] b64_char(input logic [5:0] idx);
    logic [7:0] v;
    v = {2'b00, idx};
    if (idx < 6'd26) begin
      b64_char = v + 8'h41;            // 'A'..'Z'
    end else if (idx < 6'd52) begin
      b64_char = v + 8'd71;            // 'a'..'z'
    end else if (idx < 6'd62) begin
      b64_char = v - 8'd4;             // '0'..'9'
    end else if (idx == 6'd62) begin
      b64_char = 8'h2b;                // '+'
    end else begin
      b64_char = 8'h2f;                // '/'
    end
  endfunction

  // Map a character to its 6-bit index, or BadIdx when outside the alphabet
  function automatic logic [7:0] char_index(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a) begin
      char_index = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      char_index = c - 8'd71;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      char_index = c + 8'd4;
    end else if (c == 8'h2b) begin
      char_index = 8'd62;
    end else if (c == 8'h2f) begin
      char_index = 8'd63;
    end else begin
      char_index = BadIdx;
    end
  endfunction

endpackage

>>> sv/base64_stream_codec_top.sv
// Top level of the base64 stream codec: input register, codec core, emitter.
// Depends on b64sc_pkg, b64sc_core and b64sc_emit.
//
// Usage: write cfg_wdata with cfg_we to pick encode (0) or decode (1); a write
// drops any group in progress and must happen only while the block is idle.
// The input channel (in_vld/in_stall) moves one byte and a last flag per
// transfer. The output channel (out_vld/out_stall) moves one result per
// transfer: out_byte, out_valid (0 on an end-only marker) and out_last.
// An accepted item waits in the input register until the emitter is free; the
// core then turns it into up to four results in one pass, and the emitter
// registers them and offers the first one on the output channel. The emitter
// sends one result per cycle while the receiver does not stall, so a new
// item enters every cycle while results keep up: encode gives four results
// per three input bytes, decode three per four characters. The single
// output port sets the sustained rate.
// When the receiver stalls, the current result holds, the next bundle waits in
// the input register, and in_stall rises once both are occupied.
// Synchronous reset clears the handshake state, mode (encode) and group state.
module base64_stream_codec_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_vld,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_vld,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       out_last
);

  logic               in_full_r;
  logic [7:0]         in_byte_r;
  logic               in_last_r;
  logic               free;
  logic               take;
  logic               acc;
  b64sc_pkg::bundle_t bundle;

  assign take     = in_full_r && free;
  assign in_stall = in_full_r && !free;
  assign acc      = in_vld && !in_stall;

  // Input register: fill on transfer, empty when the core takes the item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (acc) begin
      in_full_r <= 1'b1;
    end else if (take) begin
      in_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      in_byte_r <= in_byte;
      in_last_r <= in_last;
    end
  end

  b64sc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item_take (take),
    .item_byte (in_byte_r),
    .item_last (in_last_r),
    .bundle    (bundle)
  );

  b64sc_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take),
    .bundle    (bundle),
    .free      (free),
    .out_vld   (out_vld),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_valid (out_valid),
    .out_last  (out_last)
  );

endmodule

>>> sv/b64sc_core.sv
// Group state and one-pass encode/decode logic of the base64 stream codec.
// Builds the result bundle for one item; depends on b64sc_pkg.
module b64sc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                item_take,
  input  logic [7:0]          item_byte,
  input  logic                item_last,
  output b64sc_pkg::bundle_t  bundle
);

  logic       mode_r;
  logic [7:0] store_r [4];
  logic [2:0] fill_r;
  logic [2:0] fill_nxt;
  logic       pad_r;
  logic       pad_nxt;
  logic       wr_en;
  logic [1:0] wr_slot;
  logic [7:0] wr_val;

  // encode path
  logic [1:0] f_enc;
  logic [2:0] nf_enc;
  logic [7:0] g0, g1, g2;
  logic [5:0] sx [4];
  logic       enc_emit;

  // decode path
  logic       is_pad;
  logic [1:0] f_dec;
  logic [7:0] cidx;
  logic [2:0] n_dec;
  logic [7:0] sl [4];
  logic [7:0] db [3];
  logic       dec_emit;

  // Encode: place the byte in the group, split three bytes into four sextets
  always_comb begin
    f_enc  = (fill_r > 3'd2) ? 2'd0 : fill_r[1:0];
    nf_enc = {1'b0, f_enc} + 3'd1;
    g0 = (f_enc == 2'd0) ? item_byte : store_r[0];
    g1 = (f_enc == 2'd1) ? item_byte : ((f_enc == 2'd2) ? store_r[1] : 8'h00);
    g2 = (f_enc == 2'd2) ? item_byte : 8'h00;
    sx[0] = g0[7:2];
    sx[1] = {g0[1:0], g1[7:4]};
    sx[2] = {g1[3:0], g2[7:6]};
    sx[3] = g2[5:0];
    enc_emit = (f_enc == 2'd2) || item_last;
  end

  // Decode: gather the group slots, missing ones read as the bad index
  always_comb begin
    is_pad = (item_byte == b64sc_pkg::PadChar);
    f_dec  = (fill_r > 3'd3) ? 2'd0 : fill_r[1:0];
    cidx   = b64sc_pkg::char_index(item_byte);
    n_dec  = is_pad ? ((fill_r > 3'd3) ? 3'd0 : fill_r) : ({1'b0, f_dec} + 3'd1);
    for (int i = 0; i < 4; i++) begin
      if (is_pad) begin
        sl[i] = (3'(i) < n_dec) ? store_r[i] : b64sc_pkg::BadIdx;
      end else if (2'(i) < f_dec) begin
        sl[i] = store_r[i];
      end else if (2'(i) == f_dec) begin
        sl[i] = cidx;
      end else begin
        sl[i] = b64sc_pkg::BadIdx;
      end
    end
    db[0] = {sl[0][5:0], sl[1][5:4]};
    db[1] = {sl[1][3:0], sl[2][5:2]};
    db[2] = {sl[2][1:0], 6'b000000} + sl[3];
    dec_emit = is_pad || (n_dec == 3'd4) || item_last;
  end

  // Select results and next state for the current mode
  always_comb begin
    bundle   = '0;
    fill_nxt = fill_r;
    pad_nxt  = pad_r;
    wr_en    = 1'b0;
    wr_slot  = f_enc;
    wr_val   = item_byte;
    if (mode_r == b64sc_pkg::ModeEnc) begin
      wr_en    = 1'b1;
      fill_nxt = enc_emit ? 3'd0 : nf_enc;
      if (enc_emit) begin
        bundle.cnt = 3'd4;
        for (int i = 0; i < 4; i++) begin
          bundle.ent[i].data   = (3'(i) < nf_enc + 3'd1) ? b64sc_pkg::b64_char(sx[i])
                                                         : b64sc_pkg::PadChar;
          bundle.ent[i].dvalid = 1'b1;
          bundle.ent[i].last   = (i == 3) && item_last;
        end
      end
    end else if (pad_r) begin
      // after a pad, drop items until the last one, which ends the message
      if (item_last) begin
        bundle.cnt         = 3'd1;
        bundle.ent[0].last = 1'b1;
        pad_nxt            = 1'b0;
        fill_nxt           = 3'd0;
      end
    end else begin
      wr_en    = !is_pad;
      wr_slot  = f_dec;
      wr_val   = cidx;
      fill_nxt = dec_emit ? 3'd0 : n_dec;
      pad_nxt  = is_pad && !item_last;
      if (dec_emit) begin
        if (n_dec >= 3'd2) begin
          bundle.cnt = n_dec - 3'd1;
          for (int i = 0; i < 3; i++) begin
            bundle.ent[i].data   = db[i];
            bundle.ent[i].dvalid = 1'b1;
            bundle.ent[i].last   = item_last && (3'(i) + 3'd2 == n_dec);
          end
        end else if (item_last) begin
          bundle.cnt         = 3'd1;
          bundle.ent[0].last = 1'b1;
        end
      end
    end
  end

  // Mode register and group control; a mode write drops any open group
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= b64sc_pkg::ModeEnc;
      fill_r <= 3'd0;
      pad_r  <= 1'b0;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
      fill_r <= 3'd0;
      pad_r  <= 1'b0;
    end else if (item_take) begin
      fill_r <= fill_nxt;
      pad_r  <= pad_nxt;
    end
  end

  // Group store holds bytes or indices; read only where already written
  always_ff @(posedge clk) begin
    if (item_take && wr_en) begin
      store_r[wr_slot] <= wr_val;
    end
  end

endmodule

>>> sv/b64sc_emit.sv
// Result bundle register and serializer of the base64 stream codec.
// Sends one result per transfer on the output channel; depends on b64sc_pkg.
module b64sc_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  b64sc_pkg::bundle_t  bundle,
  output logic                free,
  output logic                out_vld,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                out_valid,
  output logic                out_last
);

  b64sc_pkg::bundle_t            bund_r;
  logic                          full_r;
  logic [b64sc_pkg::IdxW-1:0]    idx_r;
  logic                          xfer;
  logic                          last_x;
  b64sc_pkg::res_t               cur;

  // Present the current entry
  assign cur       = bund_r.ent[idx_r];
  assign out_vld   = full_r;
  assign out_byte  = cur.data;
  assign out_valid = cur.dvalid;
  assign out_last  = cur.last;

  assign xfer   = full_r && !out_stall;
  assign last_x = xfer && ({1'b0, idx_r} == bund_r.cnt - 3'd1);
  assign free   = !full_r || last_x;

  // Load a new bundle when the old one drains, else advance per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      idx_r  <= '0;
    end else if (load && free && bundle.cnt != 3'd0) begin
      full_r <= 1'b1;
      idx_r  <= '0;
    end else if (last_x) begin
      full_r <= 1'b0;
    end else if (xfer) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      bund_r <= bundle;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> (bund_r.cnt != 3'd0) && ({1'b0, idx_r} < bund_r.cnt))
    else $error("bundle index outside its count");

  a_hold_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && !last_x) |=> full_r)
    else $error("bundle dropped before its last entry");

  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    (full_r && !cur.dvalid) |-> cur.last)
    else $error("end-only marker without last flag");

endmodule

>>> sim/tb_base64_stream_codec_top.sv
// Testbench for base64_stream_codec_top: encode and decode runs checked against an
// in-bench codec predictor, with random idling on both channels.
// Depends on b64sc_pkg and base64_stream_codec_top.
module tb_base64_stream_codec_top;

  localparam int CycleLimit   = 200000;
  localparam int SettleCycles = 6;
  localparam int RandomItems  = 210;
  localparam logic [511:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       cfg_we    = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       in_vld    = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte   = 8'h00;
  logic       in_last   = 1'b0;
  logic       out_vld;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;

  base64_stream_codec_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_vld    (in_vld),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_vld   (out_vld),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_valid (out_valid),
    .out_last  (out_last)
  );

  // Codec state mirrored by the predictor
  logic            mode_q   = b64sc_pkg::ModeEnc;
  logic [7:0]      grp [4];
  int              fill     = 0;
  bit              pad_seen = 1'b0;
  b64sc_pkg::res_t codec_out_due [$];

  int err_count = 0;
  int n_items   = 0;
  int n_cycles  = 0;
  int rx_left   = 0;
  bit tx_jitter = 1'b0;
  bit rx_jitter = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [7:0] alpha_char(input logic [5:0] idx);
    int pos;
    pos = 63 - int'(idx);
    return Alphabet[8*pos +: 8];
  endfunction

  // Look the character up in the alphabet; anything else is an invalid index
  function automatic logic [7:0] alpha_index(input logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (alpha_char(6'(i)) == c) return 8'(i);
    end
    return b64sc_pkg::BadIdx;
  endfunction

  function automatic void push_result(input logic [7:0] d, input logic v, input logic l);
    b64sc_pkg::res_t r;
    r.data   = d;
    r.dvalid = v;
    r.last   = l;
    codec_out_due = {codec_out_due, r};
  endfunction

  // Join the held indices into three bytes; unfilled slots count as invalid,
  // and the last byte adds the whole fourth index with wraparound
  function automatic logic [23:0] joined_bits(input int n);
    logic [7:0] sl [4];
    for (int i = 0; i < 4; i++) begin
      sl[i] = (i < n) ? grp[i] : b64sc_pkg::BadIdx;
    end
    return {sl[0][5:0], sl[1][5:4], sl[1][3:0], sl[2][5:2],
            {sl[2][1:0], 6'b000000} + sl[3]};
  endfunction

  task automatic encode_byte(input logic [7:0] c, input logic last);
    logic [23:0] word;
    int          n;
    if (fill > 2) fill = 0;
    grp[fill] = c;
    fill++;
    if (fill == 3 || last) begin
      n = fill;
      word = {grp[0], (n > 1) ? grp[1] : 8'h00, (n > 2) ? grp[2] : 8'h00};
      for (int i = 0; i < 4; i++) begin
        push_result((i <= n) ? alpha_char(word[23-6*i -: 6]) : b64sc_pkg::PadChar, 1'b1,
                    last && i == 3);
      end
      fill = 0;
    end
  endtask

  // Emit the bytes of a partial decode group, or an end marker if none and last
  task automatic flush_partial(input logic last);
    logic [23:0] bits;
    int          n;
    int          k;
    n = fill;
    k = 0;
    bits = joined_bits(n);
    for (int i = 0; i + 1 < n && i < 3; i++) begin
      push_result(bits[23-8*i -: 8], 1'b1, last && (i + 2 == n));
      k++;
    end
    if (k == 0 && last) push_result(8'h00, 1'b0, 1'b1);
    fill = 0;
  endtask

  task automatic decode_char(input logic [7:0] c, input logic last);
    logic [23:0] bits;
    if (pad_seen) begin
      if (last) begin
        push_result(8'h00, 1'b0, 1'b1);
        pad_seen = 1'b0;
        fill = 0;
      end
      return;
    end
    if (c == b64sc_pkg::PadChar) begin
      flush_partial(last);
      pad_seen = !last;
      return;
    end
    if (fill > 3) fill = 0;
    grp[fill] = alpha_index(c);
    fill++;
    if (fill == 4) begin
      bits = joined_bits(4);
      for (int i = 0; i < 3; i++) push_result(bits[23-8*i -: 8], 1'b1, last && i == 2);
      fill = 0;
    end else if (last) begin
      flush_partial(1'b1);
    end
  endtask

  task automatic run_codec(input logic [7:0] c, input logic last);
    // skip the count for characters dropped after a pad
    if (!(mode_q == b64sc_pkg::ModeDec && pad_seen && !last)) n_items++;
    if (mode_q == b64sc_pkg::ModeEnc) encode_byte(c, last);
    else decode_char(c, last);
  endtask

  // Offer one item, hold it until the transfer, then predict its results
  task automatic send_item(input logic [7:0] b, input logic last);
    logic stalled;
    if (tx_jitter && $urandom_range(0, 5) == 0) begin
      in_vld <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_vld  <= 1'b1;
    in_byte <= b;
    in_last <= last;
    // sample the stall mid-cycle, so it is the value seen at the next edge
    forever begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
      if (!stalled) break;
    end
    run_codec(b, last);
  endtask

  task automatic send_chars(input string s, input logic end_last);
    for (int i = 0; i < s.len(); i++) send_item(s[i], end_last && i == s.len() - 1);
  endtask

  task automatic send_text(input logic [7:0] txt [$]);
    for (int i = 0; i < txt.size(); i++) send_item(txt[i], i == txt.size() - 1);
  endtask

  // Hold the sender until every predicted result has arrived
  task automatic wait_drained();
    in_vld <= 1'b0;
    while (codec_out_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_q   = m;
    fill     = 0;
    pad_seen = 1'b0;
  endtask

  task automatic test_encode_basics();
    write_mode(b64sc_pkg::ModeEnc);
    send_chars("Man", 1'b1);
    send_item(8'h00, 1'b1);
    send_item(8'hff, 1'b0);
    send_item(8'hff, 1'b1);
  endtask

  task automatic test_decode_basics();
    write_mode(b64sc_pkg::ModeDec);
    send_chars("TWFu", 1'b1);
    // pad ends the group early, then junk up to the last item
    send_chars("TQ=x!", 1'b1);
    send_chars("TWE=", 1'b1);
    send_chars("T", 1'b1);
    send_chars("=", 1'b1);
    // characters outside the alphabet, then '/' and '+'
    send_item(8'h00, 1'b0);
    send_item(8'hff, 1'b0);
    send_item("/", 1'b0);
    send_item("+", 1'b1);
  endtask

  task automatic test_mode_write_drops();
    write_mode(b64sc_pkg::ModeDec);
    send_chars("TW", 1'b0);
    write_mode(b64sc_pkg::ModeEnc);
    send_chars("a", 1'b1);
    send_item(8'h5a, 1'b0);
    send_item(8'ha5, 1'b0);
    write_mode(b64sc_pkg::ModeEnc);
    send_chars("Man", 1'b1);
    write_mode(b64sc_pkg::ModeDec);
    send_chars("TQ=", 1'b0);
    write_mode(b64sc_pkg::ModeDec);
    send_chars("TWFu", 1'b1);
  endtask

  task automatic random_message();
    logic [7:0] txt [$];
    int         kind;
    int         tail;
    kind = $urandom_range(0, 9);
    if (mode_q == b64sc_pkg::ModeEnc) begin
      repeat ((kind == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8))
        txt = {txt, 8'($urandom_range(0, 255))};
    end else if (kind < 7) begin
      // well-formed text: whole groups, then an optional padded tail
      repeat ($urandom_range(0, 4) * 4) txt = {txt, alpha_char(6'($urandom_range(0, 63)))};
      tail = $urandom_range(0, 2);
      if (tail == 0 && txt.size() == 0) tail = 1;
      if (tail != 0) begin
        repeat (tail + 1) txt = {txt, alpha_char(6'($urandom_range(0, 63)))};
        repeat (3 - tail) txt = {txt, b64sc_pkg::PadChar};
      end
    end else if (kind < 9) begin
      repeat ($urandom_range(1, 10))
        txt = {txt, ($urandom_range(0, 7) == 0) ? b64sc_pkg::PadChar
                                                : 8'($urandom_range(0, 255))};
    end else begin
      // early pad followed by junk
      repeat ($urandom_range(1, 7)) txt = {txt, alpha_char(6'($urandom_range(0, 63)))};
      txt = {txt, b64sc_pkg::PadChar};
      repeat ($urandom_range(0, 4)) txt = {txt, 8'($urandom_range(0, 255))};
    end
    send_text(txt);
  endtask

  task automatic test_random_traffic();
    int goal;
    int phase_end;
    goal = n_items + RandomItems;
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
    while (n_items < goal) begin
      // run the final stretch without idling
      if (n_items > goal - 40) begin
        tx_jitter = 1'b0;
        rx_jitter = 1'b0;
      end
      write_mode(1'($urandom_range(0, 1)));
      phase_end = n_items + $urandom_range(15, 45);
      while (n_items < phase_end && n_items < goal) random_message();
    end
  endtask

  // Receiver stalls in random bursts
  always @(posedge clk) begin
    if (rx_left != 0) rx_left--;
    else if (rx_jitter && $urandom_range(0, 7) == 0) rx_left = $urandom_range(1, 18);
    out_stall <= (rx_left != 0);
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin : check_results
    b64sc_pkg::res_t want;
    if (rst_n && out_vld && !out_stall) begin
      if (codec_out_due.size() == 0) begin
        $error("unexpected result: out_byte %02h out_valid %0b out_last %0b",
               out_byte, out_valid, out_last);
        err_count++;
      end else begin
        want = codec_out_due.pop_front();
        if (out_byte !== want.data) begin
          $error("out_byte: expected %02h, got %02h", want.data, out_byte);
          err_count++;
        end
        if (out_valid !== want.dvalid) begin
          $error("out_valid: expected %0b, got %0b", want.dvalid, out_valid);
          err_count++;
        end
        if (out_last !== want.last) begin
          $error("out_last: expected %0b, got %0b", want.last, out_last);
          err_count++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CycleLimit) begin
      $display("tb_base64_stream_codec_top: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_encode_basics();
    test_decode_basics();
    test_mode_write_drops();
    test_random_traffic();
    wait_drained();
    repeat (10) @(posedge clk);
    if (err_count == 0 && codec_out_due.size() == 0) begin
      $display("tb_base64_stream_codec_top: done, clean");
    end else begin
      $display("tb_base64_stream_codec_top: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/b64sc_pkg.sv
sv/b64sc_core.sv
sv/b64sc_emit.sv
sv/base64_stream_codec_top.sv
sim/tb_base64_stream_codec_top.sv
